// ===== rtl/core/decc_pkg.sv =====
package decc_pkg;

    localparam int CODE_BITS   = 16;
    localparam int DATA_BITS   = 8;
    localparam int CHECK_BITS  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CHECK_BITS-1:0] syn_t;

    // Columns of the parity-check matrix, one per code position.
    localparam syn_t H_COLS [CODE_BITS] = '{
        8'h9C, 8'hCF, 8'h2B, 8'h5D, 8'hF5, 8'hE2, 8'h5A, 8'h6C,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        FIX_NONE = 2'd0,
        FIX_ONE  = 2'd1,
        FIX_TWO  = 2'd2,
        FIX_FAIL = 2'd3
    } fix_t;

    typedef struct packed {
        logic                 req_type;
        logic [CODE_BITS-1:0] in_word;
    } in_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] out_word;
        logic [DATA_BITS-1:0] out_byte;
        logic [1:0]           fix_status;
    } out_t;

    // Work handed from the classifier to the corrector.
    typedef struct packed {
        logic [CODE_BITS-1:0] word;
        syn_t                 syndrome;
        logic                 need_pair;
        fix_t                 status;
    } entry_t;

    function automatic syn_t syndrome_of(input logic [CODE_BITS-1:0] word);
        syn_t s;
        s = '0;
        for (int j = 0; j < CODE_BITS; j++) begin
            if (word[j]) begin
                s = s ^ H_COLS[j];
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/double_error_correcting_codec.sv =====
// Channel   Ports                          Payload fields
// input     s_valid, s_ready, s_data       req_type, in_word
// result    m_valid, m_ready, m_data       out_word, out_byte, fix_status
//
// One transaction per cycle sustained while m_ready is held high; a result is
// registered first in a queue slot at the accepting edge and then in the output
// register before it is presented.
// The classifier computes the syndrome and the single-bit fix in the input
// cycle; the pair search runs between the queue head and the output register.
// aresetn is synchronous, active low, and clears the queue and output valid.
// A stalled result side fills the two-entry queue; s_ready then drops.
module double_error_correcting_codec (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  decc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output decc_pkg::out_t m_data
);

    decc_pkg::entry_t front_entry;
    decc_pkg::entry_t head_entry;
    logic             head_valid;
    logic             head_ready;

    decc_front u_front (
        .req   (s_data),
        .entry (front_entry)
    );

    decc_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_entry (front_entry),
        .rd_valid (head_valid),
        .rd_ready (head_ready),
        .rd_entry (head_entry)
    );

    decc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (head_valid),
        .q_ready (head_ready),
        .q_entry (head_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/decc_front.sv =====
module decc_front (
    input  decc_pkg::in_t    req,
    output decc_pkg::entry_t entry
);

    logic [decc_pkg::CODE_BITS-1:0] data_word;
    logic [decc_pkg::CODE_BITS-1:0] single_mask;
    decc_pkg::syn_t                 check_bits;
    decc_pkg::syn_t                 syn;

    assign data_word  = {{(decc_pkg::CODE_BITS-decc_pkg::DATA_BITS){1'b0}},
                         req.in_word[decc_pkg::DATA_BITS-1:0]};
    assign check_bits = decc_pkg::syndrome_of(data_word);
    assign syn        = decc_pkg::syndrome_of(req.in_word);

    // Columns are distinct, so at most one position matches.
    always_comb begin
        for (int j = 0; j < decc_pkg::CODE_BITS; j++) begin
            single_mask[j] = (syn == decc_pkg::H_COLS[j]);
        end
    end

    always_comb begin
        entry.syndrome  = syn;
        entry.need_pair = 1'b0;
        entry.status    = decc_pkg::FIX_NONE;
        entry.word      = req.in_word;
        if (req.req_type == decc_pkg::REQ_ENCODE) begin
            entry.word = {check_bits, req.in_word[decc_pkg::DATA_BITS-1:0]};
        end else if (syn == '0) begin
            entry.word = req.in_word;
        end else if (|single_mask) begin
            entry.word   = req.in_word ^ single_mask;
            entry.status = decc_pkg::FIX_ONE;
        end else begin
            entry.need_pair = 1'b1;
            entry.status    = decc_pkg::FIX_FAIL;
        end
    end

endmodule

// ===== rtl/core/decc_fifo.sv =====
module decc_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  decc_pkg::entry_t wr_entry,
    output logic             rd_valid,
    input  logic             rd_ready,
    output decc_pkg::entry_t rd_entry
);

    decc_pkg::entry_t               slot_reg [decc_pkg::QUEUE_DEPTH];
    logic [decc_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [decc_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [decc_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic                           do_wr, do_rd;

    localparam logic [decc_pkg::QPTR_BITS-1:0] LAST_PTR =
        decc_pkg::QPTR_BITS'(decc_pkg::QUEUE_DEPTH - 1);
    localparam logic [decc_pkg::QCNT_BITS-1:0] FULL_COUNT =
        decc_pkg::QCNT_BITS'(decc_pkg::QUEUE_DEPTH);

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/core/decc_back.sv =====
module decc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  decc_pkg::entry_t q_entry,
    output logic             m_valid,
    input  logic             m_ready,
    output decc_pkg::out_t   m_data
);

    logic [decc_pkg::CODE_BITS-1:0] pair_hit [decc_pkg::CODE_BITS];
    logic [decc_pkg::CODE_BITS-1:0] row_any;
    logic [decc_pkg::CODE_BITS-1:0] first_row;
    logic [decc_pkg::CODE_BITS-1:0] pair_mask;
    logic [decc_pkg::CODE_BITS-1:0] fixed_word;
    decc_pkg::fix_t                 fixed_status;
    decc_pkg::out_t                 out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           take;

    // Every pair (i, k) with syndrome ^ col(i) == col(k).
    always_comb begin
        for (int i = 0; i < decc_pkg::CODE_BITS; i++) begin
            for (int k = 0; k < decc_pkg::CODE_BITS; k++) begin
                pair_hit[i][k] =
                    ((q_entry.syndrome ^ decc_pkg::H_COLS[i]) == decc_pkg::H_COLS[k]);
            end
            row_any[i] = |pair_hit[i];
        end
    end

    // Keep the lowest i that pairs with some column.
    assign first_row = row_any & ~(row_any - 1'b1);

    always_comb begin
        pair_mask = '0;
        for (int i = 0; i < decc_pkg::CODE_BITS; i++) begin
            if (first_row[i]) begin
                pair_mask = pair_mask | pair_hit[i] |
                            (decc_pkg::CODE_BITS'(1) << i);
            end
        end
    end

    always_comb begin
        fixed_word   = q_entry.word;
        fixed_status = q_entry.status;
        if (q_entry.need_pair && (row_any != '0)) begin
            fixed_word   = q_entry.word ^ pair_mask;
            fixed_status = decc_pkg::FIX_TWO;
        end
    end

    assign take    = q_valid && (!out_valid_reg || m_ready);
    assign q_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (take) begin
            out_next.out_word   = fixed_word;
            out_next.out_byte   = fixed_word[decc_pkg::DATA_BITS-1:0];
            out_next.fix_status = fixed_status;
            out_valid_next      = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== dv/double_error_correcting_codec_checker.sv =====
`timescale 1ns / 100ps

module double_error_correcting_codec_checker
    import decc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   mismatches,
    output int   pending
);

    // Parity-check matrix, one 16-bit mask per check row.
    localparam logic [15:0] ROW_MASK [8] = '{
        16'h011E, 16'h0266, 16'h049B, 16'h08CF,
        16'h1059, 16'h20B4, 16'h40FA, 16'h8033
    };

    out_t codec_results [$];

    function automatic logic [7:0] parity_checks(input logic [15:0] word);
        logic [7:0] s;
        for (int r = 0; r < 8; r++) begin
            s[r] = ^(word & ROW_MASK[r]);
        end
        return s;
    endfunction

    function automatic logic [7:0] matrix_column(input int j);
        logic [7:0] c;
        for (int r = 0; r < 8; r++) begin
            c[r] = ROW_MASK[r][j];
        end
        return c;
    endfunction

    // Lowest code position whose column equals s, -1 if none.
    function automatic int position_of(input logic [7:0] s);
        int pos;
        pos = -1;
        for (int j = 15; j >= 0; j--) begin
            if (matrix_column(j) == s) begin
                pos = j;
            end
        end
        return pos;
    endfunction

    function automatic out_t codec_result(input in_t item);
        out_t       res;
        logic [15:0] w;
        logic [7:0] s;
        int         c;
        int         k;
        fix_t       st;
        w  = item.in_word;
        st = FIX_NONE;
        if (req_t'(item.req_type) == REQ_ENCODE) begin
            w = {parity_checks({8'h00, w[7:0]}), w[7:0]};
        end else begin
            s = parity_checks(w);
            if (s != 8'h00) begin
                c = position_of(s);
                if (c >= 0) begin
                    w[c] = ~w[c];
                    st   = FIX_ONE;
                end else begin
                    // Search pairs from the lowest column upward; first hit wins.
                    st = FIX_FAIL;
                    for (int i = 0; i < 16 && st == FIX_FAIL; i++) begin
                        k = position_of(s ^ matrix_column(i));
                        if (k >= 0) begin
                            w[k] = ~w[k];
                            w[i] = ~w[i];
                            st   = FIX_TWO;
                        end
                    end
                end
            end
        end
        res.out_word   = w;
        res.out_byte   = w[7:0];
        res.fix_status = st;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_t exp;
        int   bad;
        bad = 0;
        if (!aresetn) begin
            codec_results.delete();
            mismatches <= 0;
            pending    <= 0;
        end else begin
            // Check the result before queuing this edge's input.
            if (m_valid && m_ready) begin
                if (codec_results.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, m_data);
                    bad++;
                end else begin
                    exp = codec_results.pop_front();
                    if (m_data.out_word !== exp.out_word) begin
                        $display("%0t: out_word expected %h actual %h",
                                 $time, exp.out_word, m_data.out_word);
                        bad++;
                    end
                    if (m_data.out_byte !== exp.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp.out_byte, m_data.out_byte);
                        bad++;
                    end
                    if (m_data.fix_status !== exp.fix_status) begin
                        $display("%0t: fix_status expected %0d actual %0d",
                                 $time, exp.fix_status, m_data.fix_status);
                        bad++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                codec_results.push_back(codec_result(s_data));
            end
            mismatches <= mismatches + bad;
            pending    <= codec_results.size();
        end
    end

endmodule

// ===== dv/double_error_correcting_codec_tb.sv =====
`timescale 1ns / 100ps

module double_error_correcting_codec_tb;

    import decc_pkg::*;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int IDLE_MAX       = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 64;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    int   mismatches;
    int   pending;
    int   idle_cycles;

    // Codewords harvested from corrected or encoded results, used as error targets.
    logic [15:0] codewords [POOL_SIZE];
    int          codeword_count;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    double_error_correcting_codec dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    double_error_correcting_codec_checker codec_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int draw_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, IDLE_MAX);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            codeword_count <= 0;
        end else if (m_valid && m_ready && m_data.fix_status != FIX_FAIL) begin
            if (codeword_count < POOL_SIZE) begin
                codewords[codeword_count] <= m_data.out_word;
                codeword_count            <= codeword_count + 1;
            end else begin
                codewords[$urandom_range(0, POOL_SIZE - 1)] <= m_data.out_word;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    int send_run;

    task automatic send_item(input req_t req, input logic [15:0] word);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data.req_type <= req;
        s_data.in_word  <= word;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the input channel idle until every outstanding transaction has returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] cw;
        int          roll;
        int          i;
        int          k;
        send_run = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Encode extremes; high byte must be ignored.
        send_item(REQ_ENCODE, 16'h0000);
        send_item(REQ_ENCODE, 16'h00FF);
        send_item(REQ_ENCODE, 16'hFF00);
        send_item(REQ_ENCODE, 16'hFFFF);
        send_item(REQ_ENCODE, 16'hA55A);
        send_item(REQ_ENCODE, 16'h0001);
        send_item(REQ_ENCODE, 16'h5A80);
        drain_results();

        cw = codewords[4];
        send_item(REQ_DECODE, cw);
        send_item(REQ_DECODE, cw ^ 16'h0001);
        send_item(REQ_DECODE, cw ^ 16'h8000);
        send_item(REQ_DECODE, cw ^ 16'h0080);
        send_item(REQ_DECODE, cw ^ 16'h0100);
        send_item(REQ_DECODE, cw ^ 16'h8001);
        send_item(REQ_DECODE, cw ^ 16'h0180);
        send_item(REQ_DECODE, cw ^ 16'hC000);
        // Triple and heavier errors, mostly beyond reach of the pair search, and two fixed raw words.
        send_item(REQ_DECODE, cw ^ 16'h0007);
        send_item(REQ_DECODE, codewords[1] ^ 16'h0F0F);
        send_item(REQ_DECODE, 16'hFFFF);
        send_item(REQ_DECODE, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                send_item(REQ_ENCODE, 16'($urandom()));
            end else begin
                cw   = codewords[$urandom_range(0, codeword_count - 1)];
                i    = $urandom_range(0, 15);
                k    = (i + $urandom_range(1, 15)) % 16;
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    send_item(REQ_DECODE, cw);
                end else if (roll < 45) begin
                    send_item(REQ_DECODE, cw ^ (16'h0001 << i));
                end else if (roll < 80) begin
                    send_item(REQ_DECODE, cw ^ (16'h0001 << i) ^ (16'h0001 << k));
                end else begin
                    send_item(REQ_DECODE, 16'($urandom()));
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        int gap;
        int recv_run;
        recv_run = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = draw_gap(recv_run);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

endmodule
